>>> hw/rtl/julian_day_to_calendar_date_core_assert.svh
// Assertion macros for the Julian date to calendar date core.
// Depends on nothing; included by the modules that carry checks.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define JDCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jdcd check failed");
// Next-cycle implication check.
`define JDCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jdcd check failed");
`else
`define JDCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JDCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/jdcd_pkg.sv
// Package for the Julian date to calendar date core: constants and tables.
// Depends on nothing.
`timescale 1ns / 1ps
package jdcd_pkg;

	// Pipeline depth, stage one takes the request.
	localparam int PIPE_DEPTH = 9;

	// Field widths of a result.
	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int FRAC_BITS = 8;

	// Conversion constants.
	localparam int unsigned GREGORIAN_START = 2299161;
	localparam int unsigned ALPHA_OFFSET = 7468865;
	localparam int unsigned ALPHA_DIV = 146097;
	localparam int unsigned B_OFFSET = 1524;
	localparam int unsigned C_OFFSET = 2442;
	localparam int unsigned C_DIV = 7305;
	localparam int unsigned D_MULT = 1461;
	localparam int unsigned YEAR_BASE_LATE = 4716;
	localparam int unsigned YEAR_BASE_EARLY = 4715;
	localparam int unsigned LAST_LATE_E = 13;
	localparam int unsigned LATE_MONTH_BASE = 13;
	localparam int unsigned FEBRUARY = 2;

	// B - D always lies in 123..488; E lies in 4..15.
	localparam int BD_W = 9;
	localparam int E_W = 5;

	// E = floor(10000 * bd / 306001) as a scaled reciprocal, exact for bd < 512.
	localparam int E_SHIFT = 28;
	localparam int E_MULT_W = 24;
	localparam longint unsigned E_MULT =
		(64'd10000 * (64'd1 << E_SHIFT) + 64'd306000) / 64'd306001;

	// Days before month E in the shifted year: floor(30.6001 * e).
	function automatic logic [BD_W-1:0] month_day_offset(input logic [E_W-1:0] e);
		logic [BD_W-1:0] ofs;
		case (e)
			5'd0: ofs = 9'd0;
			5'd1: ofs = 9'd30;
			5'd2: ofs = 9'd61;
			5'd3: ofs = 9'd91;
			5'd4: ofs = 9'd122;
			5'd5: ofs = 9'd153;
			5'd6: ofs = 9'd183;
			5'd7: ofs = 9'd214;
			5'd8: ofs = 9'd244;
			5'd9: ofs = 9'd275;
			5'd10: ofs = 9'd306;
			5'd11: ofs = 9'd336;
			5'd12: ofs = 9'd367;
			5'd13: ofs = 9'd397;
			5'd14: ofs = 9'd428;
			5'd15: ofs = 9'd459;
			5'd16: ofs = 9'd489;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

endpackage

>>> hw/rtl/jdcd_in_if.sv
// Request channel of the core: valid, ready and the Julian date.
// Depends on nothing.
`timescale 1ns / 1ps
interface jdcd_in_if #(parameter int JD_W = 30);
	logic            valid;
	logic            ready;
	logic [JD_W-1:0] julian_date;

	modport source(output valid, output julian_date, input ready);
	modport sink(input valid, input julian_date, output ready);
endinterface

>>> hw/rtl/jdcd_out_if.sv
// Result channel of the core: valid, ready and the calendar date fields.
// Depends on jdcd_pkg for the field widths.
`timescale 1ns / 1ps
interface jdcd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [jdcd_pkg::YEAR_W-1:0]  year;
	logic [jdcd_pkg::MONTH_W-1:0]        month;
	logic [jdcd_pkg::DAY_W-1:0]          day;
	logic [jdcd_pkg::FRAC_BITS-1:0]      day_fraction;

	modport source(output valid, output year, output month, output day,
		output day_fraction, input ready);
	modport sink(input valid, input year, input month, input day,
		input day_fraction, output ready);
endinterface

>>> hw/rtl/julian_day_to_calendar_date_core.sv
// Top level of the Julian date to calendar date core (Meeus inverse method).
// Depends on jdcd_pkg, jdcd_in_if, jdcd_out_if, jdcd_recip_div and the assert header.
//
// Usage:
// The request channel jdate carries a Julian date in unsigned fixed point,
// DAY_NUMBER_BITS integer bits and 8 fraction bits; connect it to a jdcd_in_if
// with JD_W = DAY_NUMBER_BITS + 8. The result channel cal carries an
// astronomical year, month, day and the fraction of the day since midnight.
// A request is taken at a rising edge with valid and ready high.
// Throughput is one date per cycle while cal.ready stays high, set by the
// nine-stage pipeline in which no stage holds more than one multiplier (the
// three divider products and the 1461*C product).
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and requests keep flowing while
// a result waits at the output register.
// When the receiver stalls, full stages hold their data and ready drops only
// once every stage is occupied; nothing is lost or repeated.
// Reset clears all valid bits at once; the data registers are not reset.
`timescale 1ns / 1ps
`include "julian_day_to_calendar_date_core_assert.svh"
module julian_day_to_calendar_date_core #(
	parameter int DAY_NUMBER_BITS = 22
) (
	input  logic   clk,
	input  logic   arst_n,
	jdcd_in_if.sink    jdate,
	jdcd_out_if.source cal
);

	import jdcd_pkg::*;

	// Derived widths.
	localparam int IN_W = DAY_NUMBER_BITS + FRAC_BITS;
	localparam int T_W = IN_W + 1;
	localparam int ZW = DAY_NUMBER_BITS + 1;
	// Alpha division numerator 4*Z - offset.
	localparam int N1 = ZW + 2;
	localparam int S1 = N1 + 18;
	localparam int M1_W = N1 + 1;
	localparam int A_W = N1 - 17;
	localparam longint unsigned M1 =
		((64'd1 << S1) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV);
	// Year count division numerator 20*B - offset.
	localparam int N2 = ZW + 5;
	localparam int S2 = N2 + 13;
	localparam int M2_W = N2 + 1;
	localparam int CW = N2 - 12;
	localparam longint unsigned M2 =
		((64'd1 << S2) + 64'(C_DIV) - 64'd1) / 64'(C_DIV);
	localparam int DP_W = CW + 11;
	localparam logic [T_W-1:0] HALF_DAY = T_W'(1) << (FRAC_BITS - 1);

	// Handshake control.
	logic [PIPE_DEPTH:1] vld_q;
	logic [PIPE_DEPTH:1] adv;

	// Stage data.
	logic [ZW-1:0]        z_s1, z_s2;
	logic                 greg_s1, greg_s2;
	logic [N1-1:0]        n1_s1;
	logic [FRAC_BITS-1:0] frac_s1, frac_s2, frac_s3, frac_s4, frac_s5;
	logic [FRAC_BITS-1:0] frac_s6, frac_s7, frac_s8, frac_s9;
	logic [ZW-1:0]        b_s3, b_s4, b_s5, b_s6;
	logic [N2-1:0]        n2_s4;
	logic [CW-1:0]        c_s6;
	logic [ZW-1:0]        d_s6;
	logic [BD_W-1:0]      bd_s7, bd_s8;
	logic [YEAR_W-1:0]    c_s7, c_s8;
	logic [YEAR_W-1:0]    year_s9;
	logic [MONTH_W-1:0]   month_s9;
	logic [DAY_W-1:0]     day_s9;

	// Combinational stage inputs.
	logic [T_W-1:0]  t_c;
	logic [ZW-1:0]   z_c;
	logic [A_W-1:0]  alpha_c;
	logic [ZW-1:0]   a_greg_c;
	logic [ZW-1:0]   b_c;
	logic [CW-1:0]   c_c;
	logic [DP_W-1:0] dprod_c;
	logic [E_W-1:0]  e_c;
	logic [E_W-1:0]  mon_c;

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		adv[PIPE_DEPTH] = !vld_q[PIPE_DEPTH] || cal.ready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign jdate.ready = adv[1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= jdate.valid;
			end
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: add half a day, split into day number and fraction.
	assign t_c = T_W'(jdate.julian_date[IN_W-1:0]) + HALF_DAY;
	assign z_c = t_c[T_W-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			z_s1    <= z_c;
			frac_s1 <= t_c[FRAC_BITS-1:0];
			greg_s1 <= (z_c >= ZW'(GREGORIAN_START));
			n1_s1   <= N1'({z_c, 2'b00}) - N1'(ALPHA_OFFSET);
		end
	end

	// Stage 2: alpha reciprocal product.
	jdcd_recip_div #(
		.N_W(N1), .M_W(M1_W), .SHIFT(S1), .Q_W(A_W), .MULT(M1_W'(M1))
	) u_alpha_div (
		.clk(clk), .en(adv[2]), .num(n1_s1), .quot(alpha_c)
	);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			z_s2    <= z_s1;
			greg_s2 <= greg_s1;
			frac_s2 <= frac_s1;
		end
	end

	// Stage 3: Gregorian correction and the 1524 day shift.
	assign a_greg_c = z_s2 + ZW'(1) + ZW'(alpha_c) - ZW'(alpha_c >> 2);
	assign b_c = (greg_s2 ? a_greg_c : z_s2) + ZW'(B_OFFSET);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			b_s3    <= b_c;
			frac_s3 <= frac_s2;
		end
	end

	// Stage 4: numerator of the year count, 20*B - 2442.
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			n2_s4   <= N2'({b_s3, 4'b0000}) + N2'({b_s3, 2'b00}) - N2'(C_OFFSET);
			b_s4    <= b_s3;
			frac_s4 <= frac_s3;
		end
	end

	// Stage 5: year count reciprocal product.
	jdcd_recip_div #(
		.N_W(N2), .M_W(M2_W), .SHIFT(S2), .Q_W(CW), .MULT(M2_W'(M2))
	) u_year_div (
		.clk(clk), .en(adv[5]), .num(n2_s4), .quot(c_c)
	);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			b_s5    <= b_s4;
			frac_s5 <= frac_s4;
		end
	end

	// Stage 6: days in the whole years, floor(1461*C / 4).
	assign dprod_c = DP_W'(c_c) * DP_W'(D_MULT);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			c_s6    <= c_c;
			d_s6    <= dprod_c[2 +: ZW];
			b_s6    <= b_s5;
			frac_s6 <= frac_s5;
		end
	end

	// Stage 7: day within the shifted year.
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			bd_s7   <= BD_W'(b_s6 - d_s6);
			c_s7    <= c_s6[YEAR_W-1:0];
			frac_s7 <= frac_s6;
		end
	end

	// Stage 8: month count reciprocal product.
	jdcd_recip_div #(
		.N_W(BD_W), .M_W(E_MULT_W), .SHIFT(E_SHIFT), .Q_W(E_W),
		.MULT(E_MULT_W'(E_MULT))
	) u_month_div (
		.clk(clk), .en(adv[8]), .num(bd_s7), .quot(e_c)
	);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			bd_s8   <= bd_s7;
			c_s8    <= c_s7;
			frac_s8 <= frac_s7;
		end
	end

	// Stage 9: day of month, month and year into the output register.
	assign mon_c = (e_c <= E_W'(LAST_LATE_E)) ? e_c - E_W'(1) : e_c - E_W'(LATE_MONTH_BASE);

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			day_s9   <= DAY_W'(bd_s8 - month_day_offset(e_c));
			month_s9 <= mon_c[MONTH_W-1:0];
			year_s9  <= (mon_c > E_W'(FEBRUARY)) ? c_s8 - YEAR_W'(YEAR_BASE_LATE)
				: c_s8 - YEAR_W'(YEAR_BASE_EARLY);
			frac_s9  <= frac_s8;
		end
	end

	assign cal.valid        = vld_q[PIPE_DEPTH];
	assign cal.year         = $signed(year_s9);
	assign cal.month        = month_s9;
	assign cal.day          = day_s9;
	assign cal.day_fraction = frac_s9;

	// Checks on the pipeline control and the divider results.
	`JDCD_ASSERT_NXT(a_req_enters, clk, arst_n, jdate.valid && jdate.ready, vld_q[1])
	`JDCD_ASSERT_IMP(a_full_stall, clk, arst_n, (&vld_q) && !cal.ready, !jdate.ready)
	`JDCD_ASSERT_IMP(a_bd_range, clk, arst_n, vld_q[7], (bd_s7 >= 9'd123) && (bd_s7 <= 9'd488))
	`JDCD_ASSERT_IMP(a_month_range, clk, arst_n, cal.valid, (cal.month >= 4'd1) && (cal.month <= 4'd12))

endmodule

>>> hw/rtl/jdcd_recip_div.sv
// Constant divider stage: registered product with a scaled reciprocal.
// The quotient is a bit slice of the registered product. No dependencies.
`timescale 1ns / 1ps
module jdcd_recip_div #(
	parameter int N_W = 8,
	parameter int M_W = 8,
	parameter int SHIFT = 8,
	parameter int Q_W = 8,
	parameter logic [M_W-1:0] MULT = '0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] num,
	output logic [Q_W-1:0] quot
);

	localparam int P_W = N_W + M_W;

	logic [P_W-1:0] prod_q;

	// Multiply by the rounded-up reciprocal; the stage advances with the pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= P_W'(num) * P_W'(MULT);
		end
	end

	// Dropping the scale bits gives the exact floor quotient.
	assign quot = prod_q[SHIFT +: Q_W];

endmodule
